/* rtl/integer_to_seven_segment_digits_top_assert.svh */
// Assertion macros for the integer to seven-segment digits block.
// Used by the checker bound to the top level; no other dependencies.
`ifndef INTEGER_TO_SEVEN_SEGMENT_DIGITS_TOP_ASSERT_SVH
`define INTEGER_TO_SEVEN_SEGMENT_DIGITS_TOP_ASSERT_SVH

// same-cycle implication
`define I2S7_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2s7 check failed");

// next-cycle implication
`define I2S7_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2s7 check failed");

`endif

/* rtl/i2s7_pkg.sv */
// Shared types, constants and the segment table for the integer to
// seven-segment digits block. No dependencies.
package i2s7_pkg;

   localparam int DEF_MAX_DIGITS = 8;
   localparam int CNT_W          = 4;   // digit_count register width

   localparam logic [1:0] BASE_MODE_RESET   = 2'd1;
   localparam logic [3:0] DIGIT_COUNT_RESET = 4'd1;

   // register indexes on the csr port (byte address / 4)
   localparam logic REG_BASE_MODE   = 1'b0;
   localparam logic REG_DIGIT_COUNT = 1'b1;

   localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;  // 2^35 / 10, rounded up

   localparam logic [6:0] SEG_MINUS = 7'h08;
   localparam logic [6:0] SEG_BLANK = 7'h00;

   typedef enum logic [1:0] {
      BASE_HEX = 2'd0,
      BASE_DEC = 2'd1,
      BASE_OCT = 2'd2,
      BASE_BIN = 2'd3
   } base_type;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_STEP,
      CONV_DONE
   } conv_state_type;

   typedef enum logic {
      EMIT_IDLE,
      EMIT_RUN
   } emit_state_type;

   // classified item, front to converter
   typedef struct packed {
      logic             valid;
      logic             neg;
      logic [31:0]      mag;
      base_type         base;
      logic [CNT_W-1:0] cells;
   } front_item_type;

   // converted item, converter to emitter (digits travel separately)
   typedef struct packed {
      logic             valid;
      logic             ovf;
      logic             neg;
      logic [CNT_W-1:0] len;
      logic [CNT_W-1:0] cells;
   } conv_item_type;

   function automatic int dig_depth(input int max_digits);
      dig_depth = (max_digits < 15) ? max_digits : 15;
   endfunction

   function automatic logic [6:0] digit_shape(input logic [3:0] d);
      logic [6:0] s;
      unique case (d)
         4'h0: s = 7'h77;
         4'h1: s = 7'h24;
         4'h2: s = 7'h5D;
         4'h3: s = 7'h6D;
         4'h4: s = 7'h2E;
         4'h5: s = 7'h6B;
         4'h6: s = 7'h7B;
         4'h7: s = 7'h25;
         4'h8: s = 7'h7F;
         4'h9: s = 7'h6F;
         4'hA: s = 7'h3F;
         4'hB: s = 7'h7A;
         4'hC: s = 7'h53;
         4'hD: s = 7'h7C;
         4'hE: s = 7'h5B;
         4'hF: s = 7'h1B;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

endpackage

/* rtl/i2s7_front.sv */
// Front end: csr registers, input acceptance, sign/magnitude split and a
// two-entry queue towards the converter. Depends on i2s7_pkg.
module i2s7_front #(
   parameter int MAX_DIGITS = i2s7_pkg::DEF_MAX_DIGITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,
   output i2s7_pkg::front_item_type item_o,
   input  logic                  pop_i
);

   logic [1:0]                   base_ff, base_in;
   logic [i2s7_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                         csr_wr;

   i2s7_pkg::front_item_type     q_ff [2];
   i2s7_pkg::front_item_type     new_item;
   logic                         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]                   cnt_ff, cnt_in;
   logic                         push;
   logic [i2s7_pkg::CNT_W-1:0]   cells;

   assign csr_wr = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      base_in  = base_ff;
      count_in = count_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            i2s7_pkg::REG_BASE_MODE:   base_in  = csr_pwdata[1:0];
            i2s7_pkg::REG_DIGIT_COUNT: count_in = csr_pwdata[i2s7_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         i2s7_pkg::REG_BASE_MODE:   csr_prdata = {30'd0, base_ff};
         i2s7_pkg::REG_DIGIT_COUNT: csr_prdata = {28'd0, count_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // counts above the cell bank are clamped
   assign cells = ({28'd0, count_ff} > 32'(MAX_DIGITS)) ?
                  i2s7_pkg::CNT_W'(MAX_DIGITS) : count_ff;

   always_comb begin
      new_item.valid = 1'b1;
      new_item.neg   = req_tdata[31];
      new_item.mag   = req_tdata[31] ? (32'd0 - req_tdata) : req_tdata;
      new_item.base  = i2s7_pkg::base_type'(base_ff);
      new_item.cells = cells;
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid & req_tready;

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_i ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop_i};
   end

   always_comb begin
      item_o       = q_ff[rd_ptr_ff];
      item_o.valid = (cnt_ff != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= i2s7_pkg::BASE_MODE_RESET;
         count_ff  <= i2s7_pkg::DIGIT_COUNT_RESET;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         base_ff   <= base_in;
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* rtl/i2s7_conv.sv */
// Converter: peels one digit per cycle off the magnitude (reciprocal
// multiply for decimal) into a digit shift bank. Depends on i2s7_pkg.
module i2s7_conv #(
   parameter int MAX_DIGITS = i2s7_pkg::DEF_MAX_DIGITS,
   localparam int DIG_DEPTH = i2s7_pkg::dig_depth(MAX_DIGITS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  i2s7_pkg::front_item_type item_i,
   output logic                    pop_o,
   output i2s7_pkg::conv_item_type  item_o,
   output logic [3:0]              dig_o [DIG_DEPTH],
   input  logic                    ready_i
);

   localparam int CW = i2s7_pkg::CNT_W;

   i2s7_pkg::conv_state_type state_ff, state_in;
   logic [31:0]              mag_ff;
   logic                     neg_ff;
   i2s7_pkg::base_type       base_ff;
   logic [CW-1:0]            cells_ff, n_ff, len_ff;
   logic                     ovf_ff;
   logic [3:0]               dig_ff [DIG_DEPTH];

   logic [63:0]              prod;
   logic [31:0]              quot, quot10, rem, nxt;
   logic [3:0]               d;
   logic [CW:0]              n_inc;
   logic                     fin, ovf, load;

   always_comb begin
      prod   = {32'd0, mag_ff} * {32'd0, i2s7_pkg::DEC_RECIP};
      quot   = {3'd0, prod[63:35]};
      quot10 = (quot << 3) + (quot << 1);
      rem    = mag_ff - quot10;
      unique case (base_ff)
         i2s7_pkg::BASE_HEX: begin d = mag_ff[3:0];         nxt = mag_ff >> 4; end
         i2s7_pkg::BASE_DEC: begin d = rem[3:0];            nxt = quot;        end
         i2s7_pkg::BASE_OCT: begin d = {1'b0, mag_ff[2:0]}; nxt = mag_ff >> 3; end
         i2s7_pkg::BASE_BIN: begin d = {3'd0, mag_ff[0]};   nxt = mag_ff >> 1; end
         default:            begin d = 4'd0;                nxt = 32'd0;       end
      endcase
   end

   // stop once the magnitude is used up or the cells are full
   always_comb begin
      n_inc = {1'b0, n_ff} + 1'b1;
      fin   = (nxt == 32'd0) || (n_inc >= {1'b0, cells_ff});
      ovf   = (nxt != 32'd0) || (cells_ff == '0) ||
              ((n_inc + {{CW{1'b0}}, neg_ff}) > {1'b0, cells_ff});
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         i2s7_pkg::CONV_IDLE: if (item_i.valid) begin
            state_in = i2s7_pkg::CONV_STEP;
         end
         i2s7_pkg::CONV_STEP: if (fin) begin
            state_in = i2s7_pkg::CONV_DONE;
         end
         i2s7_pkg::CONV_DONE: if (ready_i) begin
            state_in = item_i.valid ? i2s7_pkg::CONV_STEP : i2s7_pkg::CONV_IDLE;
         end
         default: state_in = i2s7_pkg::CONV_IDLE;
      endcase
   end

   always_comb begin
      load         = item_i.valid && ((state_ff == i2s7_pkg::CONV_IDLE) ||
                     ((state_ff == i2s7_pkg::CONV_DONE) && ready_i));
      pop_o        = load;
      item_o.valid = (state_ff == i2s7_pkg::CONV_DONE);
      item_o.ovf   = ovf_ff;
      item_o.neg   = neg_ff;
      item_o.len   = len_ff;
      item_o.cells = cells_ff;
      dig_o        = dig_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2s7_pkg::CONV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff   <= item_i.mag;
         neg_ff   <= item_i.neg;
         base_ff  <= item_i.base;
         cells_ff <= item_i.cells;
         n_ff     <= '0;
      end else if (state_ff == i2s7_pkg::CONV_STEP) begin
         mag_ff <= nxt;
         if (n_ff < cells_ff) begin
            // newest digit enters at the bottom; bottom ends as the leading digit
            dig_ff[0] <= d;
            for (int k = 1; k < DIG_DEPTH; k++) begin
               dig_ff[k] <= dig_ff[k-1];
            end
            n_ff <= n_inc[CW-1:0];
         end
         if (fin) begin
            ovf_ff <= ovf;
            len_ff <= n_inc[CW-1:0];
         end
      end
   end

endmodule

/* rtl/i2s7_emit.sv */
// Emitter: walks the cells left to right, one result per cycle unless rsp is
// stalled, into a registered output stage. Depends on i2s7_pkg.
module i2s7_emit #(
   parameter int MAX_DIGITS = i2s7_pkg::DEF_MAX_DIGITS,
   localparam int DIG_DEPTH = i2s7_pkg::dig_depth(MAX_DIGITS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  i2s7_pkg::conv_item_type item_i,
   input  logic [3:0]             dig_i [DIG_DEPTH],
   output logic                   ready_o,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int CW = i2s7_pkg::CNT_W;

   i2s7_pkg::emit_state_type state_ff, state_in;
   logic [3:0]               dig_ff [DIG_DEPTH];
   logic [CW-1:0]            len_ff, r_ff, idx_ff;
   logic                     neg_ff, ovf_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [2:0]               rsp_idx_ff;
   logic [6:0]               rsp_mask_ff, mask;
   logic                     rsp_ovf_ff, rsp_last_ff;
   logic                     slot_free, produce, last, load;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign load      = (state_ff == i2s7_pkg::EMIT_IDLE) && item_i.valid;
   assign produce   = (state_ff == i2s7_pkg::EMIT_RUN) && slot_free;
   assign last      = ovf_ff || (r_ff == '0);
   assign ready_o   = (state_ff == i2s7_pkg::EMIT_IDLE);

   always_comb begin
      priority if (r_ff < len_ff) begin
         mask = i2s7_pkg::digit_shape(dig_ff[0]);
      end else if ((r_ff == len_ff) && neg_ff) begin
         mask = i2s7_pkg::SEG_MINUS;
      end else begin
         mask = i2s7_pkg::SEG_BLANK;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         i2s7_pkg::EMIT_IDLE: if (item_i.valid) begin
            state_in = i2s7_pkg::EMIT_RUN;
         end
         i2s7_pkg::EMIT_RUN: if (produce && last) begin
            state_in = i2s7_pkg::EMIT_IDLE;
         end
         default: state_in = i2s7_pkg::EMIT_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2s7_pkg::EMIT_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dig_ff <= dig_i;
         len_ff <= item_i.len;
         neg_ff <= item_i.neg;
         ovf_ff <= item_i.ovf;
         r_ff   <= item_i.cells - 1'b1;
         idx_ff <= '0;
      end else if (produce) begin
         r_ff   <= r_ff - 1'b1;
         idx_ff <= idx_ff + 1'b1;
         if (r_ff < len_ff) begin
            for (int k = 0; k < DIG_DEPTH - 1; k++) begin
               dig_ff[k] <= dig_ff[k+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_idx_ff  <= ovf_ff ? 3'd0 : idx_ff[2:0];
         rsp_mask_ff <= ovf_ff ? i2s7_pkg::SEG_BLANK : mask;
         rsp_ovf_ff  <= ovf_ff;
         rsp_last_ff <= last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_mask_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/integer_to_seven_segment_digits_top.sv */
// Top level of the integer to seven-segment digits block.
// Depends on i2s7_pkg, i2s7_front, i2s7_conv and i2s7_emit.
//
// Usage:
//  req_*  : one signed 32-bit value per transaction.
//  rsp_*  : one transaction per digit cell, leftmost first, tlast on the final
//           cell; a value that does not fit gives a single transaction with
//           tuser (overflow) set, cell 0, mask 0 and tlast.
//  csr_*  : register 0 (addr 0) base_mode, register 1 (addr 4) digit_count.
//           Write them only while no value is in flight.
// Flow: the digit converter peels off one digit per cycle (decimal through a
// 32x32 reciprocal multiply), then the cell emitter walks the cells; the two
// overlap, so the converter works on the next value while the emitter emits
// the last one, and each cell leaves through a registered output stage.
// A two-entry queue in front takes values while the back end is busy.
// Reset: registers return to decimal and one cell; queue and pipeline empty.
// A stall on rsp holds the output register; the emitter, converter and queue
// then fill up in turn before req_tready drops.
module integer_to_seven_segment_digits_top #(
   parameter int MAX_DIGITS = i2s7_pkg::DEF_MAX_DIGITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] cell_index, [9:3] segment_mask, rest 0
   output logic        rsp_tuser,   // [0] overflow
   output logic        rsp_tlast    // last_cell
);

   localparam int DIG_DEPTH = i2s7_pkg::dig_depth(MAX_DIGITS);

   i2s7_pkg::front_item_type front_item;
   i2s7_pkg::conv_item_type  conv_item;
   logic                     front_pop, emit_ready;
   logic [3:0]               conv_dig [DIG_DEPTH];

   assign csr_pready = 1'b1;

   i2s7_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .item_o      (front_item),
      .pop_i       (front_pop)
   );

   i2s7_conv #(.MAX_DIGITS(MAX_DIGITS)) u_conv (
      .clock   (clock),
      .reset   (reset),
      .item_i  (front_item),
      .pop_o   (front_pop),
      .item_o  (conv_item),
      .dig_o   (conv_dig),
      .ready_i (emit_ready)
   );

   i2s7_emit #(.MAX_DIGITS(MAX_DIGITS)) u_emit (
      .clock      (clock),
      .reset      (reset),
      .item_i     (conv_item),
      .dig_i      (conv_dig),
      .ready_o    (emit_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/i2s7_chk.sv */
// Port-level checker for the integer to seven-segment digits block, bound
// to the top level. Depends on integer_to_seven_segment_digits_top_assert.svh.
`include "integer_to_seven_segment_digits_top_assert.svh"

module i2s7_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   logic       rsp_acc;
   logic [2:0] exp_idx_ff, exp_idx_in;

   assign rsp_acc = rsp_tvalid & rsp_tready;

   always_comb begin
      exp_idx_in = exp_idx_ff;
      if (rsp_acc) begin
         exp_idx_in = rsp_tlast ? 3'd0 : exp_idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= 3'd0;
      end else begin
         exp_idx_ff <= exp_idx_in;
      end
   end

   `I2S7_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `I2S7_ASSERT_NOW(a_ovf_single, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast && (rsp_tdata == 16'd0))
   `I2S7_ASSERT_NOW(a_cell_order, clock, reset, rsp_acc, rsp_tdata[2:0] == exp_idx_ff)
   `I2S7_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && req_tready)

endmodule

bind integer_to_seven_segment_digits_top i2s7_chk u_i2s7_chk (.*);

/* tb/sv/integer_to_seven_segment_digits_top_test.sv */
// Self-checking testbench for integer_to_seven_segment_digits_top: formats signed
// values into digit-cell masks and checks every cell transaction against its own model.
// Depends on i2s7_pkg and the RTL of the block; nothing else.
module integer_to_seven_segment_digits_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int CELL_LIMIT     = i2s7_pkg::DEF_MAX_DIGITS;

   // segment shapes for digits 0..F (bit 0 top ... bit 6 bottom)
   localparam logic [6:0] GLYPH [16] = '{
      7'h77, 7'h24, 7'h5D, 7'h6D, 7'h2E, 7'h6B, 7'h7B, 7'h25,
      7'h7F, 7'h6F, 7'h3F, 7'h7A, 7'h53, 7'h7C, 7'h5B, 7'h1B
   };

   typedef struct {
      logic [2:0] cell_index;
      logic [6:0] segment_mask;
      logic       overflow;
      logic       last_cell;
   } cell_item_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // [31:0] value
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // [2:0] cell_index, [9:3] segment_mask, rest 0
   logic        rsp_tuser;          // [0] overflow
   logic        rsp_tlast;          // last_cell

   logic [31:0]   pending_values [$];
   cell_item_type expected_cells [$];
   cell_item_type observed_cell;

   i2s7_pkg::base_type display_base = i2s7_pkg::base_type'(i2s7_pkg::BASE_MODE_RESET);
   logic [3:0]         cell_count   = i2s7_pkg::DIGIT_COUNT_RESET;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatch_count     = 0;
   int values_sent        = 0;
   int cells_checked      = 0;
   int overflows_checked  = 0;
   int settings_used      = 1;
   int idle_cycles        = 0;

   integer_to_seven_segment_digits_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Expected cell transactions for one value under the current register copy.
   function automatic void format_cells(input logic [31:0] value);
      logic [3:0]    digits [32];
      logic [31:0]   mag;
      logic          neg;
      int            len;
      int            cells;
      int            pos;
      cell_item_type item;
      neg   = value[31];
      mag   = neg ? (32'd0 - value) : value;
      len   = 0;
      cells = (cell_count > CELL_LIMIT) ? CELL_LIMIT : int'(cell_count);
      do begin
         case (display_base)
            i2s7_pkg::BASE_HEX: begin digits[len] = mag[3:0]; mag = mag >> 4; end
            i2s7_pkg::BASE_DEC: begin digits[len] = 4'(mag % 10); mag = mag / 10; end
            i2s7_pkg::BASE_OCT: begin digits[len] = {1'b0, mag[2:0]}; mag = mag >> 3; end
            default:            begin digits[len] = {3'b0, mag[0]}; mag = mag >> 1; end
         endcase
         len++;
      end while (mag != 0);
      if (cells == 0 || len + int'(neg) > cells) begin
         item = '{cell_index: 3'd0, segment_mask: i2s7_pkg::SEG_BLANK,
                  overflow: 1'b1, last_cell: 1'b1};
         expected_cells.push_back(item);
      end else begin
         for (int i = 0; i < cells; i++) begin
            pos = cells - 1 - i;   // counted from the right
            item.cell_index = 3'(i);
            if (pos < len)
               item.segment_mask = GLYPH[digits[pos]];
            else if (pos == len && neg)
               item.segment_mask = i2s7_pkg::SEG_MINUS;
            else
               item.segment_mask = i2s7_pkg::SEG_BLANK;
            item.overflow  = 1'b0;
            item.last_cell = (i == cells - 1);
            expected_cells.push_back(item);
         end
      end
   endfunction

   // Driver: one value per transaction from the pending queue.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            format_cells(req_tdata);
            values_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_values.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_values.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each cell transaction with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cells.size() == 0) begin
               report_mismatch($sformatf("unexpected cell transaction tdata=%h tuser=%b tlast=%b",
                                         rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               observed_cell = expected_cells.pop_front();
               cells_checked++;
               if (observed_cell.overflow)
                  overflows_checked++;
               if (rsp_tdata[2:0] !== observed_cell.cell_index)
                  report_mismatch($sformatf("cell_index %0d, want %0d",
                                            rsp_tdata[2:0], observed_cell.cell_index));
               if (rsp_tdata[9:3] !== observed_cell.segment_mask)
                  report_mismatch($sformatf("segment_mask %h, want %h (cell %0d)",
                                            rsp_tdata[9:3], observed_cell.segment_mask,
                                            observed_cell.cell_index));
               if (rsp_tuser !== observed_cell.overflow)
                  report_mismatch($sformatf("overflow %b, want %b",
                                            rsp_tuser, observed_cell.overflow));
               if (rsp_tlast !== observed_cell.last_cell)
                  report_mismatch($sformatf("last_cell %b, want %b (cell %0d)",
                                            rsp_tlast, observed_cell.last_cell,
                                            observed_cell.cell_index));
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog: cycles with no transaction on any port.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] timeout: no transaction for %0d cycles", $realtime, idle_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic drain_and_settle();
      while (pending_values.size() > 0 || req_tvalid || expected_cells.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // written at this edge
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == i2s7_pkg::REG_BASE_MODE)
         display_base = i2s7_pkg::base_type'(data[1:0]);
      else
         cell_count = data[3:0];
      @(posedge clock);
   endtask

   // Only once the block is empty; the sender holds off meanwhile.
   task automatic configure(input i2s7_pkg::base_type base, input logic [3:0] count);
      drain_and_settle();
      write_register(i2s7_pkg::REG_BASE_MODE, {30'd0, base});
      write_register(i2s7_pkg::REG_DIGIT_COUNT, {28'd0, count});
      settings_used++;
   endtask

   initial begin
      i2s7_pkg::base_type base;
      logic [3:0]         count;
      logic [31:0]        v;
      int                 bits;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset setting is decimal in a single cell
      pending_values = '{32'd0, 32'd9, 32'hFFFF_FFFF, 32'd10};
      configure(i2s7_pkg::BASE_HEX, 4'd8);
      pending_values = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                         32'h0ABC_DEF9, 32'h0123_4567};
      // no cells at all: always overflow
      configure(i2s7_pkg::BASE_OCT, 4'd0);
      pending_values = '{32'd0};
      // count above the cell limit is clamped
      configure(i2s7_pkg::BASE_BIN, 4'd15);
      pending_values = '{32'd0, 32'd255, 32'd256, -32'sd127, 32'h8000_0000};
      configure(i2s7_pkg::BASE_DEC, 4'd9);
      pending_values = '{32'd99999999, -32'sd9999999, 32'h8000_0000, 32'd12345678};

      // random: idling plan per phase, two settings per phase
      for (int phase = 0; phase < 4; phase++) begin
         for (int part = 0; part < 2; part++) begin
            base  = i2s7_pkg::base_type'($urandom_range(3));
            count = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                             : 4'($urandom_range(8, 1));
            configure(base, count);
            case (phase)
               0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
               1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
               2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
               default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
            endcase
            for (int n = 0; n < 13; n++) begin
               case ($urandom_range(5))
                  0: v = $urandom();
                  1: begin
                     case ($urandom_range(3))
                        0: v = 32'h7FFF_FFFF;
                        1: v = 32'h8000_0000;
                        2: v = 32'hFFFF_FFFF;
                        default: v = 32'd0;
                     endcase
                  end
                  default: begin
                     // magnitude sized to mostly fit the current cells
                     case (base)
                        i2s7_pkg::BASE_HEX: bits = 4 * count;
                        i2s7_pkg::BASE_BIN: bits = count;
                        default:            bits = 3 * count;
                     endcase
                     bits = $urandom_range((bits > 32) ? 32 : bits);
                     v    = (bits == 0) ? 32'd0 : ($urandom() >> (32 - bits));
                     if ($urandom_range(1))
                        v = 32'd0 - v;
                  end
               endcase
               pending_values.push_back(v);
            end
         end
      end

      drain_and_settle();
      $display("Sent %0d values under %0d register settings, all bases, cell counts 0 to 15,",
               values_sent, settings_used);
      $display("with idle and stall phases; %0d cell transactions checked, %0d overflow.",
               cells_checked, overflows_checked);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
